/* sv/tps_pkg.sv */
// shared types and constants of the typing touchpad suppressor
package tps_pkg;

  localparam int KeyWords = 4;
  localparam int WordBits = 64;
  localparam int TimeBits = 32;
  localparam int CfgIdxBits = 3;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] REG_IDLE_MS       = 3'd0;
  localparam logic [CfgIdxBits-1:0] REG_IGNORE_COMBOS = 3'd1;
  localparam logic [CfgIdxBits-1:0] REG_KEY_MASK_0    = 3'd2;
  localparam logic [CfgIdxBits-1:0] REG_KEY_MASK_1    = 3'd3;
  localparam logic [CfgIdxBits-1:0] REG_KEY_MASK_2    = 3'd4;
  localparam logic [CfgIdxBits-1:0] REG_KEY_MASK_3    = 3'd5;

  // write actions
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_ENABLE  = 2'd1;
  localparam logic [1:0] ACT_DISABLE = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic       suppressed;
    logic       typing_seen;
  } tps_result_t;

endpackage

/* sv/tps_out_buf.sv */
// two-entry result queue between the decision logic and the output port
module tps_out_buf
  import tps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  tps_result_t push_word,
  output logic        full,
  output logic        out_valid,
  input  logic        out_stall,
  output tps_result_t out_word
);

  tps_result_t head;
  tps_result_t tail;
  logic [1:0]  count;
  logic        pop;

  assign pop       = out_valid && !out_stall;
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_word  = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count == 2'd2) begin
        head <= tail;
        tail <= push_word;
      end else begin
        head <= push_word;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        head <= push_word;
      end else begin
        tail <= push_word;
      end
    end else if (pop) begin
      head <= tail;
    end
  end

endmodule

/* sv/typing_touchpad_suppressor_top.sv */
// top level of the typing touchpad suppressor
//
// usage
// - input channel: one word per keyboard poll (256-bit key-down map in four
//   64-bit slices, millisecond timestamp, current device on/off state),
//   accepted on a rising edge with in_valid high and in_stall low
// - output channel: one result word per poll (write action, suppressed flag,
//   typing flag), taken on a rising edge with out_valid high and out_stall low
// - configuration: cfg_we writes cfg_data into register cfg_index
//   (0 idle_ms, 1 ignore_combos, 2..5 key masks); other indexes are dropped
// - the result is registered in the result queue and leaves after any words ahead of it
// - throughput: one poll per cycle while the queue is not full, set by the single
//   pass of decision logic from the ports into the two-entry result queue
// - a stalled receiver fills the queue; in_stall rises only when both
//   entries are held, and the queued words leave in order
// - reset: registers return to their defaults, the queue empties, and the
//   first poll afterwards only records the key map
module typing_touchpad_suppressor_top
  import tps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CfgIdxBits-1:0] cfg_index,
  input  logic [WordBits-1:0]   cfg_data,
  // poll channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [WordBits-1:0]   keys_down_0,
  input  logic [WordBits-1:0]   keys_down_1,
  input  logic [WordBits-1:0]   keys_down_2,
  input  logic [WordBits-1:0]   keys_down_3,
  input  logic [TimeBits-1:0]   now_ms,
  input  logic                  device_on,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            action,
  output logic                  suppressed,
  output logic                  typing_seen
);

  // configuration registers
  logic [TimeBits-1:0]           idle_ms;
  logic                          ignore_combos;
  logic [KeyWords*WordBits-1:0]  key_mask;

  // poll state
  logic [KeyWords*WordBits-1:0]  previous_keys;
  logic signed [TimeBits+1:0]    last_typing_ms;
  logic                          primed;
  logic                          suppressed_flag;
  logic                          saved_on;

  logic [KeyWords*WordBits-1:0]  keys;
  logic                          accept;
  logic                          buf_full;
  logic                          typing;
  logic signed [TimeBits+2:0]    now_ext;
  logic signed [TimeBits+2:0]    idle_ext;
  logic signed [TimeBits+2:0]    last_sel;
  logic signed [TimeBits+2:0]    last_fix;
  logic                          enable;
  logic signed [TimeBits+1:0]    last_typing_ms_next;
  logic                          suppressed_flag_next;
  logic                          saved_on_next;
  tps_result_t                   result;
  tps_result_t                   out_word;

  assign keys     = {keys_down_3, keys_down_2, keys_down_1, keys_down_0};
  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_ms       <= TimeBits'(1000);
      ignore_combos <= 1'b0;
      key_mask      <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IDLE_MS:       idle_ms <= cfg_data[TimeBits-1:0];
        REG_IGNORE_COMBOS: ignore_combos <= cfg_data[0];
        REG_KEY_MASK_0:    key_mask[0*WordBits +: WordBits] <= cfg_data;
        REG_KEY_MASK_1:    key_mask[1*WordBits +: WordBits] <= cfg_data;
        REG_KEY_MASK_2:    key_mask[2*WordBits +: WordBits] <= cfg_data;
        REG_KEY_MASK_3:    key_mask[3*WordBits +: WordBits] <= cfg_data;
        default: ;
      endcase
    end
  end

  // decision for one poll
  always_comb begin
    now_ext  = $signed({3'b000, now_ms});
    idle_ext = $signed({3'b000, idle_ms});

    // a newly pressed watched key, unless combos are ignored and an
    // unwatched key is held
    typing = |(keys & ~previous_keys & key_mask);
    if (ignore_combos && |(keys & ~key_mask)) begin
      typing = 1'b0;
    end

    last_sel = typing ? now_ext : (TimeBits+3)'(last_typing_ms);
    // clock went backwards: put the last typing time just out of reach
    if (last_sel > now_ext) begin
      last_fix = now_ext - idle_ext - (TimeBits+3)'(1);
    end else begin
      last_fix = last_sel;
    end
    enable = now_ext > (last_fix + idle_ext);

    suppressed_flag_next = suppressed_flag;
    saved_on_next        = saved_on;
    result.action        = ACT_NONE;
    if (suppressed_flag && enable) begin
      suppressed_flag_next = 1'b0;
      result.action        = saved_on ? ACT_ENABLE : ACT_DISABLE;
    end else if (!suppressed_flag && !enable && saved_on) begin
      saved_on_next        = device_on;
      suppressed_flag_next = 1'b1;
      result.action        = ACT_DISABLE;
    end
    last_typing_ms_next = last_fix[TimeBits+1:0];
    result.typing_seen  = typing;

    // priming poll only records the key map
    if (!primed) begin
      suppressed_flag_next = suppressed_flag;
      saved_on_next        = saved_on;
      last_typing_ms_next  = last_typing_ms;
      result.action        = ACT_NONE;
      result.typing_seen   = 1'b0;
    end
    result.suppressed = suppressed_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_keys   <= '0;
      last_typing_ms  <= '0;
      primed          <= 1'b0;
      suppressed_flag <= 1'b0;
      saved_on        <= 1'b1;
    end else if (accept) begin
      previous_keys   <= keys;
      last_typing_ms  <= last_typing_ms_next;
      primed          <= 1'b1;
      suppressed_flag <= suppressed_flag_next;
      saved_on        <= saved_on_next;
    end
  end

  // result queue decouples the poll side from a stalling receiver
  tps_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_word (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  assign action      = out_word.action;
  assign suppressed  = out_word.suppressed;
  assign typing_seen = out_word.typing_seen;

endmodule

/* sim/tb.sv */
// testbench for the typing touchpad suppressor: queued polls, predicted results, checks
`timescale 1ns / 100ps

module tb;
  import tps_pkg::*;

  // index codes outside the register list, written to show they are dropped
  localparam logic [CfgIdxBits-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxBits-1:0] REG_SPARE_HI = 3'd7;

  // one keyboard poll as it crosses the input channel
  typedef struct packed {
    logic [KeyWords-1:0][WordBits-1:0] keys;
    logic [TimeBits-1:0]               now;
    logic                              dev;
  } poll_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CfgIdxBits-1:0] cfg_index;
  logic [WordBits-1:0]   cfg_data;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [WordBits-1:0]   keys_down_0 = '0;
  logic [WordBits-1:0]   keys_down_1 = '0;
  logic [WordBits-1:0]   keys_down_2 = '0;
  logic [WordBits-1:0]   keys_down_3 = '0;
  logic [TimeBits-1:0]   now_ms = '0;
  logic                  device_on = 1'b1;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            action;
  logic                  suppressed;
  logic                  typing_seen;

  typing_touchpad_suppressor_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .keys_down_0 (keys_down_0),
    .keys_down_1 (keys_down_1),
    .keys_down_2 (keys_down_2),
    .keys_down_3 (keys_down_3),
    .now_ms      (now_ms),
    .device_on   (device_on),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .action      (action),
    .suppressed  (suppressed),
    .typing_seen (typing_seen)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // polls waiting to be driven, and results owed by the block in order
  poll_t       poll_q[$];
  tps_result_t verdict_q[$];

  // register copies, kept in step with every write
  logic [31:0]                       idle_cfg;
  logic                              combos_cfg;
  logic [KeyWords-1:0][WordBits-1:0] mask_cfg;

  // suppressor state as the predictor sees it
  logic [KeyWords-1:0][WordBits-1:0] last_keys;
  logic signed [33:0]                last_typed_ms;
  logic                              primed;
  logic                              held_off;
  logic                              dev_saved;

  // stimulus generator state: a running clock and a keyboard that evolves
  logic [255:0] gen_keys;
  logic [31:0]  gen_now;

  logic bursts_on;
  logic poll_taken = 1'b0;
  int   send_gap = 0;
  int   hold_cnt = 0;
  int   polls_queued = 0;
  int   polls_taken = 0;
  int   n_results = 0;
  int   n_bad = 0;
  int   n_enable = 0;
  int   n_disable = 0;
  int   n_typed = 0;

  // what the block owes for one poll, updating the predicted state
  function automatic tps_result_t judge_poll(poll_t p);
    tps_result_t        r;
    logic               hit;
    logic               re_enable;
    logic signed [33:0] now_s;
    logic signed [33:0] idle_s;
    int                 w;
    r.action = ACT_NONE;
    hit = 1'b0;
    now_s = $signed({2'b00, p.now});
    idle_s = $signed({2'b00, idle_cfg});
    // priming poll: remember the key map and nothing more
    if (!primed) begin
      last_keys = p.keys;
      primed = 1'b1;
      r.suppressed = held_off;
      r.typing_seen = 1'b0;
      return r;
    end
    // a watched key that went down since the last poll
    for (w = 0; w < KeyWords; w++)
      if ((p.keys[w] & ~last_keys[w] & mask_cfg[w]) != '0)
        hit = 1'b1;
    // combo mode: any held key outside the mask cancels it
    if (combos_cfg)
      for (w = 0; w < KeyWords; w++)
        if ((p.keys[w] & ~mask_cfg[w]) != '0)
          hit = 1'b0;
    last_keys = p.keys;
    if (hit)
      last_typed_ms = now_s;
    // clock went backwards: pretend the idle time has just run out
    if (last_typed_ms > now_s)
      last_typed_ms = now_s - idle_s - 34'sd1;
    re_enable = now_s > last_typed_ms + idle_s;
    if (held_off && re_enable) begin
      held_off = 1'b0;
      r.action = dev_saved ? ACT_ENABLE : ACT_DISABLE;
    end else if (!held_off && !re_enable && dev_saved) begin
      // device state is captured only on the way into suppression
      dev_saved = p.dev;
      held_off = 1'b1;
      r.action = ACT_DISABLE;
    end
    r.suppressed = held_off;
    r.typing_seen = hit;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_poll(input logic [255:0] k, input logic [31:0] t, input logic d);
    poll_t p;
    p.keys = k;
    p.now = t;
    p.dev = d;
    poll_q.push_back(p);
    polls_queued++;
  endtask

  // mostly small steps of time and a key or two toggled; now and then a
  // backward jump, a long gap or a completely random word
  task automatic push_random(input int n, input int unsigned span);
    int          i;
    int          j;
    int          bit_at;
    int unsigned pick;
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        gen_now += $urandom_range(0, span);
        bit_at = $urandom_range(0, 255);
        gen_keys[bit_at] = ~gen_keys[bit_at];
        if ($urandom_range(0, 1) == 1) begin
          bit_at = $urandom_range(0, 255);
          gen_keys[bit_at] = ~gen_keys[bit_at];
        end
        if ($urandom_range(0, 9) == 0)
          gen_keys = '0;
      end else if (pick < 80) begin
        gen_now -= $urandom_range(0, 4 * span);
      end else if (pick < 88) begin
        for (j = 0; j < 8; j++)
          gen_keys[j*32 +: 32] = $urandom;
        gen_now = $urandom;
      end else begin
        gen_now += $urandom_range(span, 4 * span);
      end
      push_poll(gen_keys, gen_now, 1'b1);
    end
  endtask

  // register write, only ever issued with the block idle
  task automatic set_reg(input logic [CfgIdxBits-1:0] idx, input logic [WordBits-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_IDLE_MS:       idle_cfg = data[31:0];
      REG_IGNORE_COMBOS: combos_cfg = data[0];
      REG_KEY_MASK_0:    mask_cfg[0] = data;
      REG_KEY_MASK_1:    mask_cfg[1] = data;
      REG_KEY_MASK_2:    mask_cfg[2] = data;
      REG_KEY_MASK_3:    mask_cfg[3] = data;
      default: ;
    endcase
  endtask

  // every queued poll taken and answered, then a short pause for the pipeline
  task automatic settle();
    while (polls_taken != polls_queued || verdict_q.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // driver: one poll word on the input side, stall bursts on the output side
  always @(negedge clk) begin : drive_ports
    poll_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      // a stalled word stays put until it has been taken
      if (!in_valid || poll_taken) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (poll_q.size() != 0) begin
          nxt = poll_q.pop_front();
          keys_down_0 <= nxt.keys[0];
          keys_down_1 <= nxt.keys[1];
          keys_down_2 <= nxt.keys[2];
          keys_down_3 <= nxt.keys[3];
          now_ms <= nxt.now;
          device_on <= nxt.dev;
          in_valid <= 1'b1;
          if (bursts_on && $urandom_range(0, 5) == 0)
            send_gap <= $urandom_range(1, 5);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (hold_cnt != 0) begin
        out_stall <= 1'b1;
        hold_cnt <= hold_cnt - 1;
      end else begin
        out_stall <= 1'b0;
        if (bursts_on && $urandom_range(0, 5) == 0)
          hold_cnt <= $urandom_range(1, 5);
      end
    end
  end

  // monitor: checks results first, then predicts for a poll taken at this edge
  always @(posedge clk) begin : watch_ports
    tps_result_t got;
    tps_result_t want;
    poll_t       seen;
    if (rst) begin
      poll_taken <= 1'b0;
    end else begin
      poll_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        got.action = action;
        got.suppressed = suppressed;
        got.typing_seen = typing_seen;
        n_results++;
        if (verdict_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("result %0d arrived with nothing expected: action %0d", n_results,
                     got.action);
        end else begin
          want = verdict_q.pop_front();
          if (got.action !== want.action || got.suppressed !== want.suppressed ||
              got.typing_seen !== want.typing_seen) begin
            n_bad++;
            if (n_bad <= 10)
              $display("result %0d: action %0d/%0d suppressed %0b/%0b typing %0b/%0b (exp/got)",
                       n_results, want.action, got.action, want.suppressed, got.suppressed,
                       want.typing_seen, got.typing_seen);
          end
        end
      end
      if (in_valid && !in_stall) begin
        seen.keys = {keys_down_3, keys_down_2, keys_down_1, keys_down_0};
        seen.now = now_ms;
        seen.dev = device_on;
        want = judge_poll(seen);
        if (want.action == ACT_ENABLE)
          n_enable++;
        if (want.action == ACT_DISABLE)
          n_disable++;
        if (want.typing_seen)
          n_typed++;
        verdict_q.push_back(want);
        polls_taken++;
      end
    end
  end

  // stimulus and phases
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_IDLE_MS;
    cfg_data = '0;
    bursts_on = 1'b1;
    idle_cfg = 32'd1000;
    combos_cfg = 1'b0;
    mask_cfg = '1;
    last_keys = '0;
    last_typed_ms = '0;
    primed = 1'b0;
    held_off = 1'b0;
    dev_saved = 1'b1;
    gen_keys = '0;
    gen_now = 32'd5000;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset defaults: priming, press, hold, idle expiry to the exact ms,
    // top of the time range, backward jump; device off only where no
    // disable can happen so the saved state stays on
    push_poll('1, 32'hffff_ffff, 1'b0);
    push_poll('0, 32'd0, 1'b1);
    push_poll(256'h1, 32'd5, 1'b0);
    push_poll(256'h1 | (256'h1 << 63), 32'd900, 1'b0);
    push_poll('1, 32'd1901, 1'b0);
    push_poll('0, 32'd2901, 1'b0);
    push_poll('0, 32'd2902, 1'b0);
    push_poll('0, 32'hffff_ffff, 1'b0);
    push_poll(256'h1 << 255, 32'hffff_ffff, 1'b1);
    push_poll('0, 32'd10, 1'b0);
    push_poll(256'h1 << 130, 32'd20, 1'b1);
    settle();

    // key 0 unwatched, combo mode: unwatched press, combo cancel, clean press
    set_reg(REG_KEY_MASK_0, ~64'h1);
    set_reg(REG_IGNORE_COMBOS, 64'h1);
    push_poll(256'h1, 32'd30, 1'b0);
    push_poll(256'h3, 32'd40, 1'b0);
    push_poll(256'h2, 32'd50, 1'b0);
    push_poll(256'h4, 32'd60, 1'b0);
    push_poll('0, 32'd1061, 1'b0);
    settle();

    // default idle, full masks, no combos
    set_reg(REG_IGNORE_COMBOS, 64'h0);
    set_reg(REG_KEY_MASK_0, '1);
    push_random(200, 600);
    settle();

    // idle of 1 ms, random masks
    set_reg(REG_IDLE_MS, 64'd1);
    set_reg(REG_KEY_MASK_0, rand64());
    set_reg(REG_KEY_MASK_1, rand64());
    set_reg(REG_KEY_MASK_2, rand64());
    set_reg(REG_KEY_MASK_3, rand64());
    push_random(120, 3);
    settle();

    // zero idle, combo mode with a few unwatched keys per slice
    set_reg(REG_IDLE_MS, 64'd0);
    set_reg(REG_IGNORE_COMBOS, 64'h1);
    set_reg(REG_KEY_MASK_0, rand64() | rand64() | rand64());
    set_reg(REG_KEY_MASK_1, rand64() | rand64() | rand64());
    set_reg(REG_KEY_MASK_2, rand64() | rand64() | rand64());
    set_reg(REG_KEY_MASK_3, rand64() | rand64() | rand64());
    push_random(120, 3);
    settle();

    // longest idle, full masks, a stretch without any idling
    bursts_on = 1'b0;
    set_reg(REG_IDLE_MS, 64'hffff_ffff);
    set_reg(REG_IGNORE_COMBOS, 64'h0);
    set_reg(REG_KEY_MASK_0, '1);
    set_reg(REG_KEY_MASK_1, '1);
    set_reg(REG_KEY_MASK_2, '1);
    set_reg(REG_KEY_MASK_3, '1);
    push_random(100, 32'd1 << 20);
    settle();

    // empty masks under combo mode, spare indexes must change nothing
    bursts_on = 1'b1;
    set_reg(REG_IDLE_MS, 64'($urandom_range(20, 5000)));
    set_reg(REG_IGNORE_COMBOS, 64'h1);
    set_reg(REG_KEY_MASK_0, '0);
    set_reg(REG_KEY_MASK_1, '0);
    set_reg(REG_KEY_MASK_2, '0);
    set_reg(REG_KEY_MASK_3, '0);
    set_reg(REG_SPARE_LO, rand64());
    set_reg(REG_SPARE_HI, rand64());
    push_random(80, idle_cfg / 2 + 1);
    settle();

    // no idling; upper bits of the idle write must be dropped
    bursts_on = 1'b0;
    set_reg(REG_IDLE_MS, {32'($urandom), 32'd300});
    set_reg(REG_IGNORE_COMBOS, 64'h0);
    set_reg(REG_KEY_MASK_0, '1);
    set_reg(REG_KEY_MASK_1, '1);
    set_reg(REG_KEY_MASK_2, '1);
    set_reg(REG_KEY_MASK_3, '1);
    push_random(150, 200);
    settle();

    // saved off state: device found off when disabling, then restored off,
    // after which typing writes nothing
    set_reg(REG_IDLE_MS, 64'd5);
    push_poll('0, 32'd0, 1'b1);
    push_poll('0, 32'd100, 1'b1);
    push_poll(256'h1 << 7, 32'd101, 1'b0);
    push_poll(256'h1 << 7, 32'd200, 1'b1);
    push_poll((256'h1 << 7) | (256'h1 << 8), 32'd201, 1'b0);
    settle();

    if (verdict_q.size() != 0) begin
      n_bad++;
      $display("%0d results never arrived", verdict_q.size());
    end
    $display("covered %0d polls and %0d results: %0d enable and %0d disable writes, %0d typed",
             polls_taken, n_results, n_enable, n_disable, n_typed);
    $display("idle times 0, 1, 1000, 300, random and maximum; masks full, empty and random");
    if (n_bad == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("run did not finish in time");
    $display("TB_ERROR");
    $finish;
  end

endmodule
